>>> hw/rtl/cdtb_pkg.sv
// cdtb_pkg: types, constants and helpers of the countdown timer with bargraph
// used by the channel interfaces, the serial divider and the top level
`timescale 1ns / 1ps

package cdtb_pkg;

   localparam int DurW        = 10;
   localparam int BarW        = 4;
   localparam int BarSegments = 8;
   localparam int BarMax      = (1 << BarW) - 1;
   localparam int ActW        = 2;
   localparam int CsrIdxW     = 1;
   // ceiling numerator: BarSegments * remaining + duration - 1
   localparam int NumW        = DurW + $clog2(BarSegments + 1);
   localparam int StepW       = $clog2(NumW + 1);

   localparam logic [DurW-1:0] ShortReset = DurW'(45);
   localparam logic [DurW-1:0] LongReset  = DurW'(180);

   typedef enum logic [ActW-1:0] {
      ACT_SECOND = 2'd0,
      ACT_HALF   = 2'd1,
      ACT_BUTTON = 2'd2
   } action_type;

   typedef enum logic [CsrIdxW-1:0] {
      CSR_SHORT = 1'd0,
      CSR_LONG  = 1'd1
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_PUBLISH
   } state_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctl_type;

   function automatic logic [BarW-1:0] bar_clamp(input logic [NumW-1:0] value);
      logic [BarW-1:0] result;
      if (value > NumW'(BarMax)) begin
         result = BarW'(BarMax);
      end else begin
         result = value[BarW-1:0];
      end
      return result;
   endfunction

endpackage

>>> hw/rtl/cdtb_ifs.sv
// cdtb_req_if and cdtb_rsp_if: valid/ready channels of the timer
// depends on cdtb_pkg for field widths
`timescale 1ns / 1ps

interface cdtb_req_if;
   import cdtb_pkg::*;
   logic            valid;
   logic            ready;
   logic [ActW-1:0] action;
   logic            button_short;
   logic            button_long;

   modport source (output valid, action, button_short, button_long, input ready);
   modport sink   (input valid, action, button_short, button_long, output ready);
endinterface

interface cdtb_rsp_if;
   import cdtb_pkg::*;
   logic            valid;
   logic            ready;
   logic            lamp_on;
   logic            tick_level;
   logic [BarW-1:0] bar_level;
   logic [DurW-1:0] seconds_left;

   modport source (output valid, lamp_on, tick_level, bar_level, seconds_left,
                   input ready);
   modport sink   (input valid, lamp_on, tick_level, bar_level, seconds_left,
                   output ready);
endinterface

>>> hw/rtl/cdtb_div.sv
// cdtb_div: bit-serial restoring divider, one quotient bit per cycle
// depends on cdtb_pkg; result clamped to the bargraph range
`timescale 1ns / 1ps

module cdtb_div (
   input  logic                      clock,
   input  logic                      reset,
   input  cdtb_pkg::div_ctl_type     ctl_in,
   input  logic [cdtb_pkg::NumW-1:0] numer,
   input  logic [cdtb_pkg::DurW-1:0] denom,
   output logic                      done,
   output logic [cdtb_pkg::BarW-1:0] quot
);
   import cdtb_pkg::*;

   logic [StepW-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [NumW-1:0]  num_ff, num_in;
   logic [DurW-1:0]  rem_ff, rem_in;
   logic [DurW-1:0]  den_ff, den_in;
   logic [DurW:0]    partial;
   logic [DurW+1:0]  diff;
   logic             fits;

   // one restoring step
   assign partial = {rem_ff, num_ff[NumW-1]};
   assign diff    = {1'b0, partial} - {2'b00, den_ff};
   assign fits    = !diff[DurW+1];

   always_comb begin
      count_in = count_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      num_in   = num_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      if (ctl_in.start) begin
         count_in = StepW'(NumW);
         busy_in  = 1'b1;
         num_in   = numer;
         rem_in   = '0;
         den_in   = denom;
      end else if (busy_ff) begin
         num_in   = {num_ff[NumW-2:0], fits};
         rem_in   = fits ? diff[DurW-1:0] : partial[DurW-1:0];
         count_in = count_ff - StepW'(1);
         if (count_ff == StepW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         busy_ff  <= busy_in;
         done_ff  <= done_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign done = done_ff;
   assign quot = bar_clamp(num_ff);

endmodule

>>> hw/rtl/countdown_timer_with_bargraph.sv
// countdown_timer_with_bargraph: lamp countdown timer with bargraph level
// depends on cdtb_pkg, cdtb_ifs and cdtb_div
//
// req_ch carries one event per item: second tick, half-second tick or a
// button event with two button flags. rsp_ch returns one item per event with
// the lamp, tick indicator, bargraph level and seconds left after the event.
// csr_we / csr_index / csr_wdata write the short and long durations; write
// them only while no event is in flight.
// Half ticks, button events and second ticks that need no bar division pass
// from ST_IDLE to ST_PUBLISH, which loads the output register once it is free.
// A second tick while running first passes through ST_DIVIDE, where the
// bit-serial divider computes the bar level and sets the pace, then through
// ST_PUBLISH. One event is worked on at a time; the next is accepted in the
// cycle after the result enters the output register, even while that
// register stalls.
// A stalled receiver holds the output register and, once the next event is
// done, blocks further acceptance until the register is taken.
// Reset clears all timer state, the lockout and the output valid flag and
// loads the durations with 45 and 180 seconds.
`timescale 1ns / 1ps

module countdown_timer_with_bargraph (
   input  logic                         clock,
   input  logic                         reset,
   cdtb_req_if.sink                     req_ch,
   cdtb_rsp_if.source                   rsp_ch,
   input  logic                         csr_we,
   input  logic [cdtb_pkg::CsrIdxW-1:0] csr_index,
   input  logic [cdtb_pkg::DurW-1:0]    csr_wdata
);
   import cdtb_pkg::*;

   state_type       state_ff, state_in;
   logic [DurW-1:0] short_ff, long_ff;
   logic [DurW-1:0] remaining_ff, remaining_in;
   logic [DurW-1:0] full_ff, full_in;
   logic            lockout_ff, lockout_in;
   logic            tick_ff, tick_in;
   logic            lamp_ff, lamp_in;
   logic [BarW-1:0] bar_ff, bar_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_lamp_ff, rsp_tick_ff;
   logic [BarW-1:0] rsp_bar_ff;
   logic [DurW-1:0] rsp_secs_ff;
   logic            accept;
   logic            publish;
   logic            need_div;
   div_ctl_type     div_ctl;
   logic [NumW-1:0] div_numer;
   logic [BarW-1:0] div_quot;
   logic            div_done;

   assign accept   = req_ch.valid && req_ch.ready;
   assign need_div = (action_type'(req_ch.action) == ACT_SECOND) &&
                     (remaining_ff != '0) && (full_ff != '0);
   assign div_numer = NumW'(BarSegments) * NumW'(remaining_ff) + NumW'(full_ff)
                      - NumW'(1);

   cdtb_div u_div (
      .clock  (clock),
      .reset  (reset),
      .ctl_in (div_ctl),
      .numer  (div_numer),
      .denom  (full_ff),
      .done   (div_done),
      .quot   (div_quot)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_ch.ready  = 1'b0;
      div_ctl.start = 1'b0;
      div_ctl.done  = div_done;
      publish       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
            if (req_ch.valid) begin
               div_ctl.start = need_div;
               state_in      = need_div ? ST_DIVIDE : ST_PUBLISH;
            end
         end
         ST_DIVIDE: begin
            if (div_ctl.done) begin
               state_in = ST_PUBLISH;
            end
         end
         ST_PUBLISH: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               publish  = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // event handling
   always_comb begin
      remaining_in = remaining_ff;
      full_in      = full_ff;
      lockout_in   = lockout_ff;
      tick_in      = tick_ff;
      lamp_in      = lamp_ff;
      bar_in       = bar_ff;
      if (accept) begin
         unique case (action_type'(req_ch.action))
            ACT_SECOND: begin
               if (remaining_ff != '0) begin
                  if (full_ff == '0) begin
                     bar_in = bar_clamp(NumW'(BarSegments));
                  end
                  remaining_in = remaining_ff - DurW'(1);
                  tick_in      = !tick_ff;
               end else begin
                  remaining_in = '0;
                  full_in      = '0;
                  tick_in      = 1'b0;
                  lamp_in      = 1'b0;
                  bar_in       = '0;
               end
            end
            ACT_HALF: begin
               lockout_in = 1'b0;
               if (remaining_ff != '0) begin
                  tick_in = !tick_ff;
               end
            end
            ACT_BUTTON: begin
               if (req_ch.button_short && !lockout_ff) begin
                  if (remaining_in != '0) begin
                     remaining_in = '0;
                     full_in      = '0;
                     tick_in      = 1'b0;
                     lamp_in      = 1'b0;
                     bar_in       = '0;
                  end else begin
                     remaining_in = short_ff - DurW'(1);
                     full_in      = short_ff;
                     tick_in      = 1'b1;
                     lamp_in      = 1'b1;
                     bar_in       = bar_clamp(NumW'(BarSegments));
                  end
               end
               if (req_ch.button_long && !lockout_ff) begin
                  if (remaining_in != '0) begin
                     remaining_in = '0;
                     full_in      = '0;
                     tick_in      = 1'b0;
                     lamp_in      = 1'b0;
                     bar_in       = '0;
                  end else begin
                     remaining_in = long_ff - DurW'(1);
                     full_in      = long_ff;
                     tick_in      = 1'b1;
                     lamp_in      = 1'b1;
                     bar_in       = bar_clamp(NumW'(BarSegments));
                  end
               end
               lockout_in = 1'b1;
            end
            default: begin
               lockout_in = lockout_ff;
            end
         endcase
      end else if (state_ff == ST_DIVIDE && div_ctl.done) begin
         bar_in = div_quot;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (publish) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         short_ff     <= ShortReset;
         long_ff      <= LongReset;
         remaining_ff <= '0;
         full_ff      <= '0;
         lockout_ff   <= 1'b0;
         tick_ff      <= 1'b0;
         lamp_ff      <= 1'b0;
         bar_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (csr_index_type'(csr_index))
               CSR_SHORT: short_ff <= csr_wdata;
               CSR_LONG:  long_ff  <= csr_wdata;
               default:   short_ff <= short_ff;
            endcase
         end
         remaining_ff <= remaining_in;
         full_ff      <= full_in;
         lockout_ff   <= lockout_in;
         tick_ff      <= tick_in;
         lamp_ff      <= lamp_in;
         bar_ff       <= bar_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (publish) begin
         rsp_lamp_ff <= lamp_ff;
         rsp_tick_ff <= tick_ff;
         rsp_bar_ff  <= bar_ff;
         rsp_secs_ff <= remaining_ff;
      end
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.lamp_on      = rsp_lamp_ff;
   assign rsp_ch.tick_level   = rsp_tick_ff;
   assign rsp_ch.bar_level    = rsp_bar_ff;
   assign rsp_ch.seconds_left = rsp_secs_ff;

   // checks
   a_done_in_divide: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside of divide state");

   a_divide_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> full_ff != '0)
      else $error("divide with zero duration");

   a_lamp_off_clear: assert property (@(posedge clock) disable iff (reset)
      !lamp_ff |-> (remaining_ff == '0) && (bar_ff == '0) && !tick_ff)
      else $error("timer state left over with lamp off");

   a_rsp_from_publish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_PUBLISH)
      else $error("result raised without a finished item");

   a_no_div_restart: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVIDE |-> !div_ctl.start)
      else $error("divider restarted while busy");

endmodule

>>> tb/tb.sv
// tb: self-checking testbench for countdown_timer_with_bargraph
// predicts each result item from its own timer model and checks it against the block
// depends on cdtb_pkg, cdtb_ifs and the top level of the timer
`timescale 1ns / 1ps

module tb;
   import cdtb_pkg::*;

   localparam logic [ActW-1:0] ActReserved = 2'd3;
   localparam int StallLimit = 2000;
   localparam int DrainCycles = 40;

   typedef struct packed {
      logic            lamp;
      logic            tick;
      logic [BarW-1:0] bar;
      logic [DurW-1:0] secs;
   } timer_view_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic [CsrIdxW-1:0] csr_index;
   logic [DurW-1:0] csr_wdata;

   cdtb_req_if req_ch ();
   cdtb_rsp_if rsp_ch ();

   countdown_timer_with_bargraph i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // timer model state
   logic [DurW-1:0] short_dur, long_dur;
   logic [DurW-1:0] secs_left, span;
   logic            locked, tick, lamp;
   logic [BarW-1:0] bar;

   timer_view_type pending_views[$];
   timer_view_type got_view, want_view;

   logic idling_on;
   int   bad_results;
   int   n_events, n_results, n_starts, n_ran_out, n_settings;
   int   stall_cycles;

   always #5 clock = ~clock;

   task automatic halt_timer();
      secs_left = '0;
      span      = '0;
      tick      = 1'b0;
      lamp      = 1'b0;
      bar       = '0;
   endtask

   task automatic press_button(input logic [DurW-1:0] dur);
      if (!locked) begin
         if (secs_left != 0) begin
            halt_timer();
         end else begin
            secs_left = dur - 10'd1;
            span      = dur;
            lamp      = 1'b1;
            tick      = 1'b1;
            bar       = BarW'(BarSegments);
            n_starts++;
         end
      end
   endtask

   task automatic predict_event(input logic [ActW-1:0] act, input logic bs, input logic bl);
      int quot;
      case (act)
         ACT_SECOND: begin
            if (secs_left != 0) begin
               if (span == 0) begin
                  bar = BarW'(BarSegments);
               end else begin
                  quot = (BarSegments * secs_left + span - 1) / span;
                  bar  = (quot > BarMax) ? BarW'(BarMax) : BarW'(quot);
               end
               secs_left = secs_left - 10'd1;
               tick      = ~tick;
               if (secs_left == 0) n_ran_out++;
            end else begin
               halt_timer();
            end
         end
         ACT_HALF: begin
            locked = 1'b0;
            if (secs_left != 0) tick = ~tick;
         end
         ACT_BUTTON: begin
            if (bs) press_button(short_dur);
            if (bl) press_button(long_dur);
            locked = 1'b1;
         end
         default: ;
      endcase
      pending_views.push_back({lamp, tick, bar, secs_left});
   endtask

   task automatic send_event(input logic [ActW-1:0] act, input logic bs, input logic bl);
      @(negedge clock);
      while (idling_on && $urandom_range(0, 99) < 14) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid        = 1'b1;
      req_ch.action       = act;
      req_ch.button_short = bs;
      req_ch.button_long  = bl;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predict_event(act, bs, bl);
      n_events++;
   endtask

   task automatic settle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_views.size() != 0) @(posedge clock);
   endtask

   task automatic write_duration(input csr_index_type idx, input logic [DurW-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      if (idx == CSR_SHORT) short_dur = value;
      else long_dur = value;
      n_settings++;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         n_results++;
         got_view = {rsp_ch.lamp_on, rsp_ch.tick_level, rsp_ch.bar_level,
                     rsp_ch.seconds_left};
         if (pending_views.size() == 0) begin
            bad_results++;
            if (bad_results <= 10)
               $display("unexpected item: lamp %0d tick %0d bar %0d secs %0d",
                        got_view.lamp, got_view.tick, got_view.bar, got_view.secs);
         end else begin
            want_view = pending_views.pop_front();
            if (got_view != want_view) begin
               bad_results++;
               if (bad_results <= 10) begin
                  $display("mismatch at item %0d: expected lamp %0d tick %0d bar %0d secs %0d",
                           n_results, want_view.lamp, want_view.tick, want_view.bar,
                           want_view.secs);
                  $display("   got lamp %0d tick %0d bar %0d secs %0d",
                           got_view.lamp, got_view.tick, got_view.bar, got_view.secs);
               end
            end
         end
      end
   end

   always @(negedge clock) rsp_ch.ready <= !idling_on || ($urandom_range(0, 99) >= 14);

   // watchdog on cycles with no item moving
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= StallLimit) begin
         $display("FAIL countdown_timer_with_bargraph");
         $finish;
      end
   end

   task automatic test_basic_sequences();
      send_event(ACT_SECOND, 1'b1, 1'b1);
      send_event(ActReserved, 1'b1, 1'b0);
      send_event(ACT_BUTTON, 1'b0, 1'b0);
      send_event(ACT_HALF, 1'b0, 1'b1);
      send_event(ACT_BUTTON, 1'b1, 1'b0);
      send_event(ACT_SECOND, 1'b0, 1'b0);
      send_event(ACT_BUTTON, 1'b0, 1'b1);
      send_event(ACT_HALF, 1'b0, 1'b0);
      send_event(ActReserved, 1'b0, 1'b1);
      send_event(ACT_BUTTON, 1'b0, 1'b1);
      send_event(ACT_HALF, 1'b1, 1'b1);
      send_event(ACT_BUTTON, 1'b1, 1'b1);
      send_event(ACT_HALF, 1'b0, 1'b0);
      send_event(ACT_BUTTON, 1'b0, 1'b1);
      send_event(ACT_SECOND, 1'b0, 1'b0);
      settle();
   endtask

   task automatic test_duration_edges();
      write_duration(CSR_SHORT, 10'd1);
      write_duration(CSR_LONG, 10'd0);
      // duration of one lights the lamp with nothing left, zero wraps around
      send_event(ACT_HALF, 1'b0, 1'b0);
      send_event(ACT_BUTTON, 1'b1, 1'b0);
      send_event(ACT_SECOND, 1'b0, 1'b0);
      send_event(ACT_HALF, 1'b0, 1'b0);
      send_event(ACT_BUTTON, 1'b0, 1'b1);
      send_event(ACT_SECOND, 1'b0, 1'b0);
      send_event(ACT_HALF, 1'b0, 1'b0);
      send_event(ACT_BUTTON, 1'b1, 1'b1);
      send_event(ACT_SECOND, 1'b0, 1'b0);
      send_event(ACT_HALF, 1'b0, 1'b0);
      send_event(ACT_BUTTON, 1'b1, 1'b0);
      settle();
   endtask

   task automatic random_events(input int count);
      int k, r, pick;
      logic [ActW-1:0] act;
      logic bs, bl;
      for (k = 0; k < count; k++) begin
         r  = $urandom_range(0, 99);
         bs = 1'($urandom_range(0, 1));
         bl = 1'($urandom_range(0, 1));
         if (r < 8) begin
            act = ActW'($urandom_range(0, 3));
         end else if (r < 45) begin
            act = ACT_HALF;
         end else if (r < ((secs_left == 0) ? 60 : 90)) begin
            act = ACT_SECOND;
         end else begin
            act  = ACT_BUTTON;
            pick = $urandom_range(0, 9);
            bs   = (pick == 0) || (pick >= 2 && pick <= 5);
            bl   = (pick == 0) || (pick >= 6);
         end
         send_event(act, bs, bl);
      end
   endtask

   function automatic logic [DurW-1:0] pick_duration();
      int r;
      r = $urandom_range(0, 9);
      case (r)
         0: return 10'd0;
         1: return 10'd1;
         2: return 10'd2;
         3: return 10'd1023;
         default: return DurW'($urandom_range(2, 40));
      endcase
   endfunction

   task automatic test_random_phases();
      int phase;
      for (phase = 0; phase < 8; phase++) begin
         settle();
         if (phase == 0) begin
            write_duration(CSR_SHORT, 10'd2);
            write_duration(CSR_LONG, 10'd1023);
         end else if (phase == 1) begin
            write_duration(CSR_SHORT, 10'd1023);
            write_duration(CSR_LONG, 10'd2);
         end else begin
            write_duration(CSR_SHORT, pick_duration());
            write_duration(CSR_LONG, pick_duration());
         end
         idling_on = (phase != 3) && (phase != 4);
         random_events(125);
      end
      idling_on = 1'b1;
      settle();
   endtask

   initial begin
      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = CSR_SHORT;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.action       = ACT_SECOND;
      req_ch.button_short = 1'b0;
      req_ch.button_long  = 1'b0;
      rsp_ch.ready        = 1'b0;
      idling_on           = 1'b1;
      bad_results         = 0;
      n_events            = 0;
      n_results           = 0;
      n_starts            = 0;
      n_ran_out           = 0;
      n_settings          = 0;
      stall_cycles        = 0;
      short_dur           = ShortReset;
      long_dur            = LongReset;
      locked              = 1'b0;
      halt_timer();
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_basic_sequences();
      test_duration_edges();
      test_random_phases();

      repeat (DrainCycles) @(posedge clock);
      if (pending_views.size() != 0) begin
         bad_results++;
         $display("%0d expected items never arrived", pending_views.size());
      end
      $display("sent %0d events, checked %0d items, %0d mismatches", n_events, n_results,
               bad_results);
      $display("countdowns started %0d, ran out %0d, duration writes %0d", n_starts,
               n_ran_out, n_settings);
      if (bad_results == 0) begin
         $display("PASS countdown_timer_with_bargraph");
      end else begin
         $display("FAIL countdown_timer_with_bargraph");
      end
      $finish;
   end

endmodule
